// ===== hdl/crqs_pkg.sv =====
// Package for the credit ready queue scheduler.
// Types, opcodes, status codes and controller states; no dependencies.
package crqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [6:0] WAKE_BONUS_RST = 7'd20;
    localparam logic [6:0] CREDIT_CAP_RST = 7'd100;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_WAKE     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;
    localparam logic [1:0] OP_FIND     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_WAKE_BONUS = 1'b0;
    localparam logic CFG_CREDIT_CAP = 1'b1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        thread_id;
        logic signed [7:0] credit;
        logic              to_expired;
    } crqs_in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        chosen_id;
        logic signed [7:0] chosen_credit;
        logic              found;
    } crqs_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HOLD
    } crqs_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture input item
        logic exec;   // perform the operation on the queues
    } crqs_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic done;
    } crqs_stat_t;

endpackage

// ===== hdl/crqs_ctrl.sv =====
// Controller of the scheduler: one item at a time through load, execute, hold.
// Depends on crqs_pkg.
module crqs_ctrl import crqs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output crqs_cmd_t  cmd,
    input  crqs_stat_t stat
);

    crqs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.done) state_next = S_HOLD;
            end
            S_HOLD: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == S_IDLE);
        m_valid  = (state_reg == S_HOLD);
        cmd.load = (state_reg == S_IDLE) && s_valid;
        cmd.exec = (state_reg == S_EXEC);
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid both high");
    a_exec_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec) else $error("load not followed by exec");
    a_hold_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && stat.done) |=> m_valid) else $error("result not shown");

endmodule

// ===== hdl/crqs_datapath.sv =====
// Datapath of the scheduler: two sorted register banks with shift insert and pop.
// Depends on crqs_pkg.
module crqs_datapath import crqs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  crqs_cmd_t  cmd,
    output crqs_stat_t stat,
    input  crqs_in_t   s_data,
    output crqs_out_t  m_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [7:0]        ids_reg  [2][QUEUE_DEPTH];
    logic signed [7:0] crs_reg  [2][QUEUE_DEPTH];
    logic [CW-1:0]     cnt_reg  [2];
    logic              act_reg;
    logic [6:0]        bonus_reg, cap_reg;
    crqs_in_t          item_reg;
    crqs_out_t         res_reg, res_next;

    logic              bank;
    logic signed [7:0] new_cr;
    logic signed [8:0] sum;
    logic              do_ins, do_pop, full;
    logic [QUEUE_DEPTH-1:0] ge;      // entry k stays ahead of the new one
    logic [QUEUE_DEPTH-1:0] hit;

    // Wake credit: saturate at the cap; insert keeps the given credit.
    always_comb begin
        sum = $signed({item_reg.credit[7], item_reg.credit}) + $signed({2'b00, bonus_reg});
        if (sum > $signed({2'b00, cap_reg})) new_cr = $signed({1'b0, cap_reg});
        else new_cr = sum[7:0];
        if (item_reg.opcode == OP_INSERT) new_cr = item_reg.credit;
    end

    always_comb begin
        bank = act_reg;
        if (item_reg.opcode == OP_INSERT && item_reg.to_expired) bank = !act_reg;
        if (item_reg.opcode == OP_DISPATCH && cnt_reg[act_reg] == '0) bank = !act_reg;
        full = (cnt_reg[bank] == CW'(QUEUE_DEPTH));
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            ge[k]  = (CW'(k) < cnt_reg[bank]) && (crs_reg[bank][k] >= new_cr);
            hit[k] = ((CW'(k) < cnt_reg[0]) && ids_reg[0][k] == item_reg.thread_id)
                  || ((CW'(k) < cnt_reg[1]) && ids_reg[1][k] == item_reg.thread_id);
        end
        do_ins = cmd.exec && !full
              && (item_reg.opcode == OP_INSERT || item_reg.opcode == OP_WAKE);
        do_pop = cmd.exec && item_reg.opcode == OP_DISPATCH && cnt_reg[bank] != '0;

        res_next = '0;
        case (item_reg.opcode)
            OP_INSERT, OP_WAKE: res_next.status = full ? ST_FULL : ST_OK;
            OP_DISPATCH: begin
                if (cnt_reg[bank] == '0) begin
                    res_next.status = ST_EMPTY;
                end else begin
                    res_next.chosen_id     = ids_reg[bank][0];
                    res_next.chosen_credit = crs_reg[bank][0];
                end
            end
            OP_FIND: res_next.found = |hit;
            default: res_next = '0;
        endcase
    end

    assign stat.done = cmd.exec;
    assign m_data    = res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        if (cmd.exec) res_reg <= res_next;
        // Shift cells: each entry takes its own, its neighbor's, or the new item.
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            if (do_ins && !ge[k]) begin
                if (k == 0 || ge[(k == 0) ? 0 : k-1]) begin
                    ids_reg[bank][k] <= item_reg.thread_id;
                    crs_reg[bank][k] <= new_cr;
                end else begin
                    ids_reg[bank][k] <= ids_reg[bank][(k == 0) ? 0 : k-1];
                    crs_reg[bank][k] <= crs_reg[bank][(k == 0) ? 0 : k-1];
                end
            end
            if (do_pop && k < QUEUE_DEPTH - 1) begin
                ids_reg[bank][k] <= ids_reg[bank][(k < QUEUE_DEPTH - 1) ? k+1 : k];
                crs_reg[bank][k] <= crs_reg[bank][(k < QUEUE_DEPTH - 1) ? k+1 : k];
            end
        end
        if (!aresetn) begin
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            act_reg    <= 1'b0;
            bonus_reg  <= WAKE_BONUS_RST;
            cap_reg    <= CREDIT_CAP_RST;
        end else begin
            if (do_ins) cnt_reg[bank] <= cnt_reg[bank] + 1'b1;
            if (do_pop) begin
                cnt_reg[bank] <= cnt_reg[bank] - 1'b1;
                act_reg       <= bank;
            end
            if (cfg_we && cfg_index == CFG_WAKE_BONUS) bonus_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_CREDIT_CAP) cap_reg   <= cfg_data;
        end
    end

    a_cnt0: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CW'(QUEUE_DEPTH)) else $error("bank 0 overflow");
    a_cnt1: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[1] <= CW'(QUEUE_DEPTH)) else $error("bank 1 overflow");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_ins && do_pop)) else $error("insert and pop together");

endmodule

// ===== hdl/credit_ready_queue_scheduler.sv =====
// Top level of the credit ready queue scheduler.
// Depends on crqs_pkg, crqs_ctrl and crqs_datapath.
//
// Two credit-sorted queues (active and expired) of QUEUE_DEPTH entries each,
// held in registers. One item is handled at a time: it is taken while idle,
// executed in the execute state, and its result is held until the output
// transfer; no new item is taken until then. Insert and wake shift all
// later entries of the target bank in one step; dispatch shifts the bank down.
// cfg_index 0 is wake_bonus, 1 is credit_cap; write only while idle.
module credit_ready_queue_scheduler import crqs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  crqs_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output crqs_out_t  m_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    crqs_cmd_t  cmd;
    crqs_stat_t stat;

    crqs_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .stat
    );

    crqs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .s_data, .m_data,
        .cfg_we, .cfg_index, .cfg_data
    );

endmodule

// ===== tb/tb_credit_ready_queue_scheduler.sv =====
// Testbench for the credit ready queue scheduler: random and directed operations
// checked against a behavioral model of the two sorted banks. Depends on crqs_pkg and the top level.
module tb_credit_ready_queue_scheduler import crqs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    crqs_in_t   s_data;
    logic       m_valid;
    logic       m_ready;
    crqs_out_t  m_data;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;

    credit_ready_queue_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow state of the scheduler.
    logic [7:0]        bank_id  [2][DEPTH];
    logic signed [7:0] bank_cr  [2][DEPTH];
    int                bank_len [2];
    logic              act_bank;
    logic [6:0]        bonus_reg;
    logic [6:0]        cap_reg;

    crqs_in_t  pending_items[$];
    crqs_out_t expected_results[$];
    int        mismatches;
    int        accepted_count;
    bit        stall_hold;   // long receiver hold-off
    bit        sender_pause; // sender waits for drain

    // Place an entry after all entries of equal or higher credit.
    function automatic logic [1:0] place_entry(logic b, logic [7:0] id,
                                               logic signed [7:0] cr);
        int pos;
        pos = 0;
        if (bank_len[b] >= DEPTH) return ST_FULL;
        while (pos < bank_len[b] && bank_cr[b][pos] >= cr) pos++;
        for (int k = bank_len[b]; k > pos; k--) begin
            bank_id[b][k] = bank_id[b][k-1];
            bank_cr[b][k] = bank_cr[b][k-1];
        end
        bank_id[b][pos] = id;
        bank_cr[b][pos] = cr;
        bank_len[b]++;
        return ST_OK;
    endfunction

    function automatic crqs_out_t schedule_op(crqs_in_t it);
        crqs_out_t r;
        int sum;
        r = '0;
        case (it.opcode)
            OP_INSERT: r.status = place_entry(act_bank ^ it.to_expired,
                                              it.thread_id, it.credit);
            OP_WAKE: begin
                sum = int'(it.credit) + int'(bonus_reg);
                if (sum > int'(cap_reg)) sum = int'(cap_reg);
                r.status = place_entry(act_bank, it.thread_id, 8'(sum));
            end
            OP_DISPATCH: begin
                if (bank_len[0] == 0 && bank_len[1] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (bank_len[act_bank] == 0) act_bank = ~act_bank;
                    r.chosen_id = bank_id[act_bank][0];
                    r.chosen_credit = bank_cr[act_bank][0];
                    for (int k = 1; k < bank_len[act_bank]; k++) begin
                        bank_id[act_bank][k-1] = bank_id[act_bank][k];
                        bank_cr[act_bank][k-1] = bank_cr[act_bank][k];
                    end
                    bank_len[act_bank]--;
                end
            end
            default: begin
                for (int b = 0; b < 2; b++)
                    for (int k = 0; k < bank_len[b]; k++)
                        if (bank_id[b][k] == it.thread_id) r.found = 1'b1;
            end
        endcase
        return r;
    endfunction

    // Driver: bursts with random gaps; predict at each transfer.
    int gap_left;
    int burst_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(schedule_op(s_data));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (sender_pause || pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    s_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus the long hold-off.
    int rx_phase;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_phase <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (stall_hold) m_ready <= 1'b0;
            else if (rx_phase[9]) m_ready <= 1'b1; // stretch with no stalls
            else m_ready <= (rx_phase % 7 != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        crqs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", m_data);
            end else begin
                want = expected_results.pop_front();
                if (m_data.status !== want.status || m_data.chosen_id !== want.chosen_id
                    || m_data.chosen_credit !== want.chosen_credit
                    || m_data.found !== want.found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    function automatic crqs_in_t make_op(logic [1:0] op, logic [7:0] id,
                                         logic [7:0] cr, logic te);
        crqs_in_t it;
        it.opcode = op;
        it.thread_id = id;
        it.credit = cr;
        it.to_expired = te;
        return it;
    endfunction

    function automatic crqs_in_t random_op();
        int sel;
        sel = $urandom_range(0, 99);
        // Small id set so finds hit; occasional full range.
        return make_op(sel < 35 ? OP_INSERT : sel < 55 ? OP_WAKE : sel < 85 ? OP_DISPATCH
                       : OP_FIND,
                       ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                       ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom),
                       1'($urandom));
    endfunction

    task automatic wait_drain();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (5) @(posedge aclk);
    endtask

    // Write one register, then drop the enable before returning.
    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_WAKE_BONUS) bonus_reg = val;
        else cap_reg = val;
        @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_WAKE_BONUS;
        cfg_data = '0;
        stall_hold = 1'b0;
        sender_pause = 1'b0;
        mismatches = 0;
        accepted_count = 0;
        bank_len[0] = 0;
        bank_len[1] = 0;
        act_bank = 1'b0;
        bonus_reg = WAKE_BONUS_RST;
        cap_reg = CREDIT_CAP_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty dispatch, extremes, wake saturation, ties, full bank, swap.
        pending_items.push_back(make_op(OP_DISPATCH, 8'hFF, 8'h7F, 1'b1));
        pending_items.push_back(make_op(OP_FIND, 8'h00, 8'h00, 1'b0));
        pending_items.push_back(make_op(OP_INSERT, 8'hFF, 8'h7F, 1'b0));
        pending_items.push_back(make_op(OP_INSERT, 8'h00, 8'h80, 1'b0));
        pending_items.push_back(make_op(OP_INSERT, 8'h11, 8'h05, 1'b1));
        pending_items.push_back(make_op(OP_INSERT, 8'h12, 8'h05, 1'b1));
        pending_items.push_back(make_op(OP_WAKE, 8'h21, 8'h7F, 1'b0));
        pending_items.push_back(make_op(OP_WAKE, 8'h22, 8'h80, 1'b1));
        pending_items.push_back(make_op(OP_WAKE, 8'h23, 8'h5A, 1'b0));
        pending_items.push_back(make_op(OP_FIND, 8'h12, 8'h00, 1'b0));
        pending_items.push_back(make_op(OP_FIND, 8'h99, 8'h00, 1'b0));
        for (int i = 0; i < 9; i++)
            pending_items.push_back(make_op(OP_DISPATCH, 8'h00, 8'h00, 1'b0));
        for (int i = 0; i < DEPTH + 1; i++)
            pending_items.push_back(make_op(OP_INSERT, 8'(i), 8'(i % 3), 1'b1));
        wait_drain();

        // Hold off the receiver so the block backs up and stalls its input.
        for (int i = 0; i < 40; i++) pending_items.push_back(random_op());
        stall_hold = 1'b1;
        repeat (200) @(posedge aclk);
        stall_hold = 1'b0;
        wait_drain();

        // Register settings, extremes among them.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_WAKE_BONUS, 7'd0);   write_reg(CFG_CREDIT_CAP, 7'd127); end
                1: begin write_reg(CFG_WAKE_BONUS, 7'd127); write_reg(CFG_CREDIT_CAP, 7'd0);   end
                2: begin write_reg(CFG_WAKE_BONUS, 7'd127); write_reg(CFG_CREDIT_CAP, 7'd127); end
                3: begin write_reg(CFG_WAKE_BONUS, 7'($urandom));
                         write_reg(CFG_CREDIT_CAP, 7'($urandom)); end
                default: begin write_reg(CFG_WAKE_BONUS, WAKE_BONUS_RST);
                               write_reg(CFG_CREDIT_CAP, CREDIT_CAP_RST); end
            endcase
            for (int i = 0; i < 290; i++) pending_items.push_back(random_op());
            // Pause the sender until all results are in, then resume.
            while (pending_items.size() > 150) @(posedge aclk);
            sender_pause = 1'b1;
            while (s_valid || expected_results.size() != 0) @(posedge aclk);
            sender_pause = 1'b0;
            wait_drain();
        end

        if (mismatches == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/crqs_pkg.sv
hdl/crqs_ctrl.sv
hdl/crqs_datapath.sv
hdl/credit_ready_queue_scheduler.sv
tb/tb_credit_ready_queue_scheduler.sv
